// ===== rtl/hrlp_pkg.sv =====
// hrlp_pkg: request/result payload types, error codes, parser modes and
// RFC 3986 character-class helpers for the HTTP request line parser.
// No dependencies.
package hrlp_pkg;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       restart;
   } req_payload_type;

   typedef struct packed {
      logic       emit_valid;
      logic [7:0] emit_char;
      logic [1:0] emit_target;
      logic       pair_start;
      logic [1:0] method_code;
      logic       method_valid;
      logic       line_done;
      logic [2:0] error_code;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      MODE_METHOD,
      MODE_PATH,
      MODE_PCT,
      MODE_KEY,
      MODE_VAL,
      MODE_VER,
      MODE_DONE
   } parse_mode_type;

   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_BAD     = 3'd1;  // 400
   localparam logic [2:0] ERR_NOTIMPL = 3'd2;  // 501
   localparam logic [2:0] ERR_URILONG = 3'd3;  // 414
   localparam logic [2:0] ERR_UPGRADE = 3'd4;  // 426
   localparam logic [2:0] ERR_VERSION = 3'd5;  // 505

   localparam logic [1:0] TGT_PATH = 2'd0;
   localparam logic [1:0] TGT_KEY  = 2'd1;
   localparam logic [1:0] TGT_VAL  = 2'd2;

   localparam logic [1:0] METH_NONE   = 2'd0;
   localparam logic [1:0] METH_GET    = 2'd1;
   localparam logic [1:0] METH_POST   = 2'd2;
   localparam logic [1:0] METH_DELETE = 2'd3;

   localparam logic [7:0] CHAR_CR = 8'h0D;

   // only the leading bytes that any match can look at are kept
   localparam int MATCH_LEN = 6;   // DELETE
   localparam int MIDX_W    = 3;
   localparam int VER_LEN   = 8;   // HTTP/d.d
   localparam int VIDX_W    = 3;

   localparam logic [15:0] URI_CAP_RESET = 16'd2048;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic is_unreserved(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == "-") || (c == ".") ||
             (c == "_") || (c == "~");
   endfunction

   function automatic logic is_subdelim(input logic [7:0] c);
      return (c == "!") || (c == "$") || (c == "&") || (c == "'") || (c == "(") ||
             (c == ")") || (c == "*") || (c == "+") || (c == ",") || (c == ";") ||
             (c == "=");
   endfunction

   function automatic logic is_path_char(input logic [7:0] c);
      return is_unreserved(c) || is_subdelim(c) || (c == ":") || (c == "@") ||
             (c == "/");
   endfunction

   function automatic logic is_query_char(input logic [7:0] c);
      return is_path_char(c) || (c == "?");
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= "A") && (c <= "F")) || ((c >= "a") && (c <= "f"));
   endfunction

   // value of a hex digit; letters map through the low nibble plus nine
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      if (is_digit(c)) begin
         v = c[3:0];
      end else begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

// ===== rtl/hrlp_if.sv =====
// hrlp_req_if / hrlp_rsp_if: valid/ready channels for parser requests and
// results. Depends on hrlp_pkg.
interface hrlp_req_if import hrlp_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hrlp_rsp_if import hrlp_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/http_request_line_parser_unit.sv =====
// http_request_line_parser_unit: byte-wide HTTP request line parser top level.
// Depends on hrlp_pkg and the channel interfaces in hrlp_if.sv.
//
//   channel   dir  handshake          payload
//   req_chan  in   valid/ready        byte_in[7:0], restart
//   rsp_chan  out  valid/ready        emit/method/line_done/error_code fields
//   csr_*     in   csr_we (no ready)  csr_wdata[15:0] -> URI length limit
//
// One byte per cycle sustained while the result side is ready.
// Input register feeds one pass of parse logic that updates the parser state
// and loads the result register in the same cycle.
// Synchronous active-high reset clears all control state; length limit -> 2048.
// A stalled result holds the pipe; a request still lands in an empty input register.
module http_request_line_parser_unit import hrlp_pkg::*; #(
   parameter int METHOD_MAX   = 11,
   parameter int VERSION_MAX  = 9,
   parameter int URI_LEN_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   hrlp_req_if.sink      req_chan,
   hrlp_rsp_if.source    rsp_chan,
   input  logic          csr_we,
   input  logic [15:0]   csr_wdata
);

   localparam int MCNT_W = $clog2(METHOD_MAX + 1);
   localparam int VCNT_W = $clog2(VERSION_MAX + 1);
   localparam int CMP_W  = (URI_LEN_BITS > 16) ? URI_LEN_BITS : 16;

   // pipeline registers
   logic            req_valid_ff;
   req_payload_type req_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;
   logic            advance;
   logic            fire;

   // parser state
   logic [15:0]             len_cap_ff;
   parse_mode_type          mode_ff, mode_in;
   logic [MCNT_W-1:0]       mcount_ff, mcount_in;
   logic [VCNT_W-1:0]       vcount_ff, vcount_in;
   logic [3:0]              hex_hi_ff, hex_hi_in;
   logic                    hex_one_ff, hex_one_in;
   logic [URI_LEN_BITS-1:0] uri_ff, uri_in;
   logic                    keyne_ff, keyne_in;
   logic [2:0]              err_ff, err_in;
   logic [7:0]              method_ff [MATCH_LEN];
   logic [7:0]              version_ff [VER_LEN];

   logic                    mwr, vwr;

   // state as seen by this byte (restart applied)
   parse_mode_type          cur_mode;
   logic [MCNT_W-1:0]       cur_mcount;
   logic [VCNT_W-1:0]       cur_vcount;
   logic [3:0]              cur_hex_hi;
   logic                    cur_hex_one;
   logic [URI_LEN_BITS-1:0] cur_uri;
   logic                    cur_keyne;
   logic [2:0]              cur_err;

   logic [7:0]              c;
   logic [URI_LEN_BITS-1:0] uri_bumped;
   logic                    uri_over;
   logic                    m_get, m_post, m_delete;
   logic [2:0]              step_err;

   function automatic logic [2:0] version_check(input logic [7:0] v [VER_LEN],
                                                input logic is6, input logic is8);
      logic [2:0] e;
      if (!is6 && !is8) begin
         e = ERR_BAD;
      end else if (v[0] != "H" || v[1] != "T" || v[2] != "T" || v[3] != "P" ||
                   v[4] != "/") begin
         e = ERR_BAD;
      end else if (!is_digit(v[5]) || (is8 && (v[6] != "." || !is_digit(v[7])))) begin
         e = ERR_BAD;
      end else if (is6) begin
         e = (v[5] <= "1") ? ERR_UPGRADE : ERR_VERSION;
      end else if (v[5] < "1") begin
         e = ERR_UPGRADE;
      end else if (v[5] > "1") begin
         e = ERR_VERSION;
      end else if (v[7] < "1") begin
         e = ERR_UPGRADE;
      end else if (v[7] > "1") begin
         e = ERR_VERSION;
      end else begin
         e = ERR_NONE;
      end
      return e;
   endfunction

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_valid_ff && advance;
   assign req_chan.ready = !req_valid_ff || advance;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign c           = req_ff.byte_in;
   assign cur_mode    = req_ff.restart ? MODE_METHOD : mode_ff;
   assign cur_mcount  = req_ff.restart ? '0 : mcount_ff;
   assign cur_vcount  = req_ff.restart ? '0 : vcount_ff;
   assign cur_hex_hi  = req_ff.restart ? 4'd0 : hex_hi_ff;
   assign cur_hex_one = req_ff.restart ? 1'b0 : hex_one_ff;
   assign cur_uri     = req_ff.restart ? '0 : uri_ff;
   assign cur_keyne   = req_ff.restart ? 1'b0 : keyne_ff;
   assign cur_err     = req_ff.restart ? ERR_NONE : err_ff;

   assign uri_bumped = (&cur_uri) ? cur_uri : cur_uri + 1'b1;
   assign uri_over   = CMP_W'(cur_uri) > CMP_W'(len_cap_ff);

   assign m_get    = (cur_mcount == MCNT_W'(3)) && method_ff[0] == "G" &&
                     method_ff[1] == "E" && method_ff[2] == "T";
   assign m_post   = (cur_mcount == MCNT_W'(4)) && method_ff[0] == "P" &&
                     method_ff[1] == "O" && method_ff[2] == "S" && method_ff[3] == "T";
   assign m_delete = (cur_mcount == MCNT_W'(6)) && method_ff[0] == "D" &&
                     method_ff[1] == "E" && method_ff[2] == "L" && method_ff[3] == "E" &&
                     method_ff[4] == "T" && method_ff[5] == "E";

   always_comb begin
      mode_in    = cur_mode;
      mcount_in  = cur_mcount;
      vcount_in  = cur_vcount;
      hex_hi_in  = cur_hex_hi;
      hex_one_in = cur_hex_one;
      uri_in     = cur_uri;
      keyne_in   = cur_keyne;
      mwr        = 1'b0;
      vwr        = 1'b0;
      step_err   = ERR_NONE;
      rsp_in     = '0;

      if (cur_err == ERR_NONE) begin
         unique case (cur_mode)
            MODE_METHOD: begin
               if (c == " ") begin
                  priority if (m_get) begin
                     rsp_in.method_code = METH_GET;
                  end else if (m_post) begin
                     rsp_in.method_code = METH_POST;
                  end else if (m_delete) begin
                     rsp_in.method_code = METH_DELETE;
                  end else begin
                     step_err = ERR_NOTIMPL;
                  end
                  rsp_in.method_valid = 1'b1;
                  mcount_in = '0;
                  mode_in   = MODE_PATH;
               end else if (!is_unreserved(c) || cur_mcount >= MCNT_W'(METHOD_MAX)) begin
                  step_err = ERR_BAD;
               end else begin
                  mwr       = cur_mcount < MCNT_W'(MATCH_LEN);
                  mcount_in = cur_mcount + 1'b1;
               end
            end
            MODE_PATH: begin
               if (c == "?") begin
                  uri_in            = uri_bumped;
                  rsp_in.pair_start = 1'b1;
                  keyne_in          = 1'b0;
                  mode_in           = MODE_KEY;
               end else if (c == " ") begin
                  mode_in = MODE_VER;
                  if (uri_over) step_err = ERR_URILONG;
               end else if (c == "%") begin
                  mode_in = MODE_PCT;
               end else if (!is_path_char(c)) begin
                  step_err = ERR_BAD;
               end else begin
                  rsp_in.emit_valid  = 1'b1;
                  rsp_in.emit_char   = c;
                  rsp_in.emit_target = TGT_PATH;
                  uri_in             = uri_bumped;
               end
            end
            MODE_PCT: begin
               if (!is_hex(c)) begin
                  step_err = ERR_BAD;
               end else if (!cur_hex_one) begin
                  hex_hi_in  = hex_value(c);
                  hex_one_in = 1'b1;
               end else begin
                  rsp_in.emit_valid  = 1'b1;
                  rsp_in.emit_char   = {cur_hex_hi, hex_value(c)};
                  rsp_in.emit_target = TGT_PATH;
                  hex_one_in         = 1'b0;
                  hex_hi_in          = 4'd0;
                  uri_in             = uri_bumped;
                  mode_in            = MODE_PATH;
               end
            end
            MODE_KEY: begin
               if (c == "=") begin
                  uri_in = uri_bumped;
                  if (!cur_keyne) step_err = ERR_BAD;
                  else mode_in = MODE_VAL;
               end else if (!is_query_char(c)) begin
                  step_err = ERR_BAD;
               end else begin
                  rsp_in.emit_valid  = 1'b1;
                  rsp_in.emit_char   = c;
                  rsp_in.emit_target = TGT_KEY;
                  keyne_in           = 1'b1;
                  uri_in             = uri_bumped;
               end
            end
            MODE_VAL: begin
               if (c == " ") begin
                  mode_in = MODE_VER;
                  if (uri_over) step_err = ERR_URILONG;
               end else if (c == "&") begin
                  uri_in            = uri_bumped;
                  rsp_in.pair_start = 1'b1;
                  keyne_in          = 1'b0;
                  mode_in           = MODE_KEY;
               end else if (!is_query_char(c)) begin
                  step_err = ERR_BAD;
               end else begin
                  rsp_in.emit_valid  = 1'b1;
                  rsp_in.emit_char   = c;
                  rsp_in.emit_target = TGT_VAL;
                  uri_in             = uri_bumped;
               end
            end
            MODE_VER: begin
               if (c == CHAR_CR) begin
                  mode_in  = MODE_DONE;
                  step_err = version_check(version_ff, cur_vcount == VCNT_W'(6),
                                           cur_vcount == VCNT_W'(8));
                  rsp_in.line_done = 1'b1;
               end else if (cur_vcount >= VCNT_W'(VERSION_MAX)) begin
                  step_err = ERR_BAD;
               end else begin
                  vwr       = cur_vcount < VCNT_W'(VER_LEN);
                  vcount_in = cur_vcount + 1'b1;
               end
            end
            MODE_DONE: begin
            end
            default: begin
            end
         endcase
      end

      // an erroring byte reports the error code alone
      if (step_err != ERR_NONE) begin
         rsp_in = '0;
      end
      err_in = (step_err != ERR_NONE) ? step_err : cur_err;
      rsp_in.error_code = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_cap_ff   <= URI_CAP_RESET;
         mode_ff      <= MODE_METHOD;
         mcount_ff    <= '0;
         vcount_ff    <= '0;
         hex_hi_ff    <= 4'd0;
         hex_one_ff   <= 1'b0;
         uri_ff       <= '0;
         keyne_ff     <= 1'b0;
         err_ff       <= ERR_NONE;
      end else begin
         if (csr_we) len_cap_ff <= csr_wdata;
         if (req_chan.ready) req_valid_ff <= req_chan.valid;
         if (advance) rsp_valid_ff <= req_valid_ff;
         if (fire) begin
            mode_ff    <= mode_in;
            mcount_ff  <= mcount_in;
            vcount_ff  <= vcount_in;
            hex_hi_ff  <= hex_hi_in;
            hex_one_ff <= hex_one_in;
            uri_ff     <= uri_in;
            keyne_ff   <= keyne_in;
            err_ff     <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) req_ff <= req_chan.payload;
      if (fire) rsp_ff <= rsp_in;
      if (fire && mwr) method_ff[cur_mcount[MIDX_W-1:0]] <= c;
      if (fire && vwr) version_ff[cur_vcount[VIDX_W-1:0]] <= c;
   end

   // a latched error only clears through restart
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ERR_NONE && !(fire && req_ff.restart)) |=> err_ff == $past(err_ff))
      else $error("latched error changed without restart");

   a_method_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.method_valid) |-> rsp_ff.method_code != METH_NONE)
      else $error("method_valid without a recognised method");

   a_emit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.emit_valid || rsp_ff.line_done)) |->
         rsp_ff.error_code == ERR_NONE)
      else $error("character or line end reported alongside an error");

   a_hex_mode: assert property (@(posedge clock) disable iff (reset)
      hex_one_ff |-> (mode_ff == MODE_PCT || err_ff != ERR_NONE))
      else $error("half a percent escape outside escape mode");

   a_uri_method: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_METHOD) |-> uri_ff == '0)
      else $error("URI length counted during the method token");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for http_request_line_parser_unit, byte-wise
// request lines against a cycle-free parser model. Depends on hrlp_pkg,
// hrlp_if.sv and the parser RTL.
module tb_top;
   import hrlp_pkg::*;

   typedef logic [7:0] char_type;

   localparam int       METH_CAP    = 11;
   localparam int       VER_CAP     = 9;
   localparam int       URI_W       = 16;
   localparam int       IDLE_PCT    = 21;
   localparam int       HOLD_CYCLES = 60;
   localparam int       STALL_LIMIT = 2000;
   localparam int       PHASE_BYTES = 275;
   localparam char_type CR          = 8'h0D;
   localparam char_type SP          = 8'h20;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;

   hrlp_req_if req_bus ();
   hrlp_rsp_if rsp_bus ();

   http_request_line_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model state
   parse_mode_type   pm;
   char_type         meth_buf [METH_CAP];
   int               meth_n;
   char_type         ver_buf [VER_CAP];
   int               ver_n;
   logic [3:0]       hi_nib;
   bit               hi_ok;
   logic [URI_W-1:0] uri_len;
   bit               key_seen;
   logic [2:0]       err_l;
   logic [15:0]      uri_cap;

   req_payload_type  line_bytes_q [$];
   rsp_payload_type  parse_out_q [$];
   char_type         line_buf [$];
   rsp_payload_type  got_r;
   rsp_payload_type  want_r;

   int bytes_offered = 0;
   int bytes_taken   = 0;
   int results_seen  = 0;
   int mismatches    = 0;
   int stall_cycles  = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   string unres_set =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-._~";
   string path_set =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-._~!$&'()*+,;=:@/";
   string query_set =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-._~!$&'()*+,;=:@/?";

   // ---------------------------------------------------------------- char classes
   function automatic bit c_digit(input char_type c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic bit c_unres(input char_type c);
      return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || c_digit(c) ||
             (c == "-") || (c == ".") || (c == "_") || (c == "~");
   endfunction

   function automatic bit c_pathc(input char_type c);
      return c_unres(c) || (c == "!") || (c == "$") || (c == "&") || (c == "'") ||
             (c == "(") || (c == ")") || (c == "*") || (c == "+") || (c == ",") ||
             (c == ";") || (c == "=") || (c == ":") || (c == "@") || (c == "/");
   endfunction

   function automatic bit c_queryc(input char_type c);
      return c_pathc(c) || (c == "?");
   endfunction

   function automatic int nib_val(input char_type c);
      if (c_digit(c)) return c - 8'h30;
      if ((c >= "A") && (c <= "F")) return c - 8'h41 + 10;
      if ((c >= "a") && (c <= "f")) return c - 8'h61 + 10;
      return -1;
   endfunction

   // ---------------------------------------------------------------- parser model
   function automatic void clear_parser();
      pm = MODE_METHOD;
      foreach (meth_buf[i]) meth_buf[i] = '0;
      foreach (ver_buf[i]) ver_buf[i] = '0;
      meth_n   = 0;
      ver_n    = 0;
      hi_nib   = '0;
      hi_ok    = 1'b0;
      uri_len  = '0;
      key_seen = 1'b0;
      err_l    = ERR_NONE;
   endfunction

   function automatic void bump_uri();
      if (uri_len != {URI_W{1'b1}}) uri_len = uri_len + 1'b1;
   endfunction

   function automatic bit meth_is(input string s);
      int i;
      if (meth_n != s.len()) return 1'b0;
      for (i = 0; i < meth_n; i++) begin
         if (meth_buf[i] != s[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [2:0] version_verdict();
      if ((ver_n != 6) && (ver_n != 8)) return ERR_BAD;
      if ((ver_buf[0] != "H") || (ver_buf[1] != "T") || (ver_buf[2] != "T") ||
          (ver_buf[3] != "P") || (ver_buf[4] != "/")) return ERR_BAD;
      if (!c_digit(ver_buf[5])) return ERR_BAD;
      if ((ver_n == 8) && ((ver_buf[6] != ".") || !c_digit(ver_buf[7]))) return ERR_BAD;
      if (ver_n == 6) return (ver_buf[5] <= "1") ? ERR_UPGRADE : ERR_VERSION;
      if (ver_buf[5] < "1") return ERR_UPGRADE;
      if (ver_buf[5] > "1") return ERR_VERSION;
      if (ver_buf[7] < "1") return ERR_UPGRADE;
      if (ver_buf[7] > "1") return ERR_VERSION;
      return ERR_NONE;
   endfunction

   function automatic rsp_payload_type parse_byte(input req_payload_type item);
      rsp_payload_type o;
      char_type        c;
      logic [2:0]      e;
      int              h;
      o = '0;
      c = item.byte_in;
      e = ERR_NONE;
      if (item.restart) clear_parser();
      if (err_l == ERR_NONE) begin
         case (pm)
            MODE_METHOD: begin
               if (c == SP) begin
                  if (meth_is("GET")) o.method_code = METH_GET;
                  else if (meth_is("POST")) o.method_code = METH_POST;
                  else if (meth_is("DELETE")) o.method_code = METH_DELETE;
                  if (o.method_code == METH_NONE) e = ERR_NOTIMPL;
                  else o.method_valid = 1'b1;
                  meth_n = 0;
                  pm = MODE_PATH;
               end else if (!c_unres(c) || (meth_n >= METH_CAP)) begin
                  e = ERR_BAD;
               end else begin
                  meth_buf[meth_n] = c;
                  meth_n++;
               end
            end
            MODE_PATH: begin
               if (c == "?") begin
                  bump_uri();
                  o.pair_start = 1'b1;
                  key_seen = 1'b0;
                  pm = MODE_KEY;
               end else if (c == SP) begin
                  pm = MODE_VER;
                  if (uri_len > uri_cap) e = ERR_URILONG;
               end else if (c == "%") begin
                  pm = MODE_PCT;
               end else if (!c_pathc(c)) begin
                  e = ERR_BAD;
               end else begin
                  o.emit_valid  = 1'b1;
                  o.emit_char   = c;
                  o.emit_target = TGT_PATH;
                  bump_uri();
               end
            end
            MODE_PCT: begin
               h = nib_val(c);
               if (h < 0) begin
                  e = ERR_BAD;
               end else if (!hi_ok) begin
                  hi_nib = h[3:0];
                  hi_ok  = 1'b1;
               end else begin
                  o.emit_valid  = 1'b1;
                  o.emit_char   = {hi_nib, h[3:0]};
                  o.emit_target = TGT_PATH;
                  hi_ok  = 1'b0;
                  hi_nib = '0;
                  bump_uri();
                  pm = MODE_PATH;
               end
            end
            MODE_KEY: begin
               if (c == "=") begin
                  bump_uri();
                  if (!key_seen) e = ERR_BAD;
                  else pm = MODE_VAL;
               end else if (!c_queryc(c)) begin
                  e = ERR_BAD;
               end else begin
                  o.emit_valid  = 1'b1;
                  o.emit_char   = c;
                  o.emit_target = TGT_KEY;
                  key_seen = 1'b1;
                  bump_uri();
               end
            end
            MODE_VAL: begin
               if (c == SP) begin
                  pm = MODE_VER;
                  if (uri_len > uri_cap) e = ERR_URILONG;
               end else if (c == "&") begin
                  bump_uri();
                  o.pair_start = 1'b1;
                  key_seen = 1'b0;
                  pm = MODE_KEY;
               end else if (!c_queryc(c)) begin
                  e = ERR_BAD;
               end else begin
                  o.emit_valid  = 1'b1;
                  o.emit_char   = c;
                  o.emit_target = TGT_VAL;
                  bump_uri();
               end
            end
            MODE_VER: begin
               if (c == CR) begin
                  pm = MODE_DONE;
                  e = version_verdict();
                  if (e == ERR_NONE) o.line_done = 1'b1;
               end else if (ver_n >= VER_CAP) begin
                  e = ERR_BAD;
               end else begin
                  ver_buf[ver_n] = c;
                  ver_n++;
               end
            end
            default: begin
            end
         endcase
         // an error step, and everything after it, carries the code alone
         if (e != ERR_NONE) begin
            err_l = e;
            o = '0;
         end
      end
      o.error_code = err_l;
      return o;
   endfunction

   // ---------------------------------------------------------------- line builder
   function automatic char_type pick(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic char_type hex_char(input logic [3:0] v, input bit upper);
      if (v < 10) return 8'h30 + v;
      return (upper ? 8'h41 : 8'h61) + v - 8'd10;
   endfunction

   function automatic string version_form(input int k);
      case (k)
         10: return "HTTP/1.0";
         11: return "HTTP/0.9";
         12: return "HTTP/2.0";
         13: return "HTTP/1.2";
         14: return "HTTP/1";
         15: return "HTTP/2";
         16: return "HTTP/0";
         17: return "HTTX/1.1";
         18: return "HTTP/1.1.1";   // one byte over the version store
         19: return "HTTP/1.1 ";    // fits, wrong shape
         20: return "HTTP/a.1";
         21: return "HTTP/1-1";
         22: return "";
         23: return "HTTP/9.9";
         default: return "HTTP/1.1";
      endcase
   endfunction

   task automatic add_byte(input char_type b);
      line_buf = {line_buf, b};
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // moves line_buf into the pending requests; random restarts only when asked
   task automatic flush_line(input bit scatter_restart);
      req_payload_type item;
      int k;
      for (k = 0; k < line_buf.size(); k++) begin
         item.byte_in = line_buf[k];
         if (!scatter_restart) item.restart = (k == 0);
         else if (k == 0) item.restart = ($urandom_range(0, 19) != 0);
         else item.restart = ($urandom_range(0, 149) == 0);
         line_bytes_q = {line_bytes_q, item};
      end
      line_buf.delete();
   endtask

   task automatic build_line();
      int       r;
      int       n;
      int       k;
      int       klen;
      char_type v;
      line_buf.delete();
      r = $urandom_range(0, 99);
      if (r < 8) begin
         n = $urandom_range(1, 16);
         repeat (n) add_byte(char_type'($urandom_range(0, 255)));
      end else begin
         r = $urandom_range(0, 99);
         if (r < 30) push_text("GET");
         else if (r < 50) push_text("POST");
         else if (r < 70) push_text("DELETE");
         else if (r < 78) repeat ($urandom_range(1, 6)) add_byte(pick(unres_set));
         else if (r < 82) begin
         end
         else if (r < 86) repeat (METH_CAP) add_byte(pick(unres_set));
         else if (r < 90) repeat (METH_CAP + 1) add_byte(pick(unres_set));
         else if (r < 95) begin
            push_text("PO");
            add_byte(char_type'($urandom_range(0, 255)));
         end else push_text("GETS");
         add_byte(SP);

         if ($urandom_range(0, 9) != 0) begin
            add_byte("/");
            n = $urandom_range(0, 6);
            repeat (n) begin
               r = $urandom_range(0, 99);
               if (r < 65) begin
                  add_byte(pick(path_set));
               end else if (r < 85) begin
                  v = char_type'($urandom_range(0, 255));
                  add_byte("%");
                  add_byte(hex_char(v[7:4], 1'($urandom_range(0, 1))));
                  add_byte(hex_char(v[3:0], 1'($urandom_range(0, 1))));
               end else if (r < 89) begin
                  add_byte("%");
                  if ($urandom_range(0, 1))
                     add_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
                  add_byte(char_type'($urandom_range(0, 255)));
               end else if (r < 92) begin
                  add_byte(char_type'($urandom_range(0, 255)));
               end else begin
                  add_byte("/");
               end
            end
         end

         if ($urandom_range(0, 99) < 45) begin
            add_byte("?");
            n = $urandom_range(1, 2);
            for (k = 0; k < n; k++) begin
               if (k > 0) add_byte("&");
               klen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
               repeat (klen) add_byte(($urandom_range(0, 29) == 0) ? SP : pick(query_set));
               // a key left without '=' runs into the closing space
               if ($urandom_range(0, 9) != 0) begin
                  add_byte("=");
                  repeat ($urandom_range(0, 3))
                     add_byte(($urandom_range(0, 29) == 0) ?
                              char_type'($urandom_range(0, 255)) : pick(query_set));
               end
            end
         end
         add_byte(SP);
         push_text(version_form($urandom_range(0, 23)));
         add_byte(CR);
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) add_byte(char_type'($urandom_range(0, 255)));
      end
      flush_line(1'b1);
   endtask

   // ---------------------------------------------------------------- sequencing
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("[%0t] result %0d: %s got %0d expected %0d", $time, results_seen, what,
               got, want);
   endtask

   task automatic set_len_cap(input logic [15:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      uri_cap    = v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic wait_idle();
      while (!((line_bytes_q.size() == 0) && (bytes_taken == bytes_offered) &&
               (parse_out_q.size() == 0))) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_phase();
      int added;
      int prev_size;
      added = 0;
      while (added < PHASE_BYTES) begin
         prev_size = line_bytes_q.size();
         build_line();
         added += line_bytes_q.size() - prev_size;
      end
   endtask

   initial begin
      int phase;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      reset           = 1'b1;
      uri_cap         = URI_CAP_RESET;
      clear_parser();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: one clean line, then byte extremes into a latched error
      push_text("GET /%7e?k=v HTTP/1.1");
      add_byte(CR);
      flush_line(1'b0);
      add_byte(8'h00);
      flush_line(1'b0);
      line_bytes_q = {line_bytes_q, req_payload_type'{byte_in: 8'hFF, restart: 1'b0}};
      wait_idle();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            1: set_len_cap(16'd0);
            2: set_len_cap(16'($urandom_range(6, 16)));
            3: set_len_cap(16'hFFFF);
            default: begin
            end
         endcase
         random_phase();
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (bytes_taken == bytes_offered) begin
         if ((line_bytes_q.size() > 0) &&
             (((bytes_offered >= 300) && (bytes_offered < 550)) ||
              ($urandom_range(0, 99) >= IDLE_PCT))) begin
            req_bus.payload <= line_bytes_q.pop_front();
            req_bus.valid   <= 1'b1;
            bytes_offered++;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result side back-pressure, with one long hold-off to fill the pipe and one stretch of steady readiness
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && (results_seen >= 200)) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if ((results_seen >= 650) && (results_seen < 900)) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            parse_out_q = {parse_out_q, parse_byte(req_bus.payload)};
            bytes_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_r = rsp_bus.payload;
            if (parse_out_q.size() == 0) begin
               report_mismatch("result with no request outstanding", got_r.error_code, -1);
            end else begin
               want_r = parse_out_q.pop_front();
               if (got_r.emit_valid !== want_r.emit_valid)
                  report_mismatch("emit_valid", got_r.emit_valid, want_r.emit_valid);
               if (got_r.emit_char !== want_r.emit_char)
                  report_mismatch("emit_char", got_r.emit_char, want_r.emit_char);
               if (got_r.emit_target !== want_r.emit_target)
                  report_mismatch("emit_target", got_r.emit_target, want_r.emit_target);
               if (got_r.pair_start !== want_r.pair_start)
                  report_mismatch("pair_start", got_r.pair_start, want_r.pair_start);
               if (got_r.method_code !== want_r.method_code)
                  report_mismatch("method_code", got_r.method_code, want_r.method_code);
               if (got_r.method_valid !== want_r.method_valid)
                  report_mismatch("method_valid", got_r.method_valid, want_r.method_valid);
               if (got_r.line_done !== want_r.line_done)
                  report_mismatch("line_done", got_r.line_done, want_r.line_done);
               if (got_r.error_code !== want_r.error_code)
                  report_mismatch("error_code", got_r.error_code, want_r.error_code);
            end
            results_seen++;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[%0t] no request or result moved for %0d cycles", $time, STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
